### rtl/core/qacc_pkg.sv
// Package with the constants, payload types and helper functions of the quaternion accumulator.
package qacc_pkg;

  // Component format: signed fixed point, COMP_W bits with FRAC_W fraction bits.
  localparam int unsigned COMP_W = 16;
  localparam int unsigned FRAC_W = 12;

  // Accumulator for four products or four squares, kept as an even number of bits.
  localparam int unsigned ACC_W = 2 * COMP_W + 2;
  // Square root: one result bit per iteration over pairs of accumulator bits.
  localparam int unsigned SQ_N = ACC_W / 2;
  localparam int unsigned ROOT_W = COMP_W + 1;
  localparam int unsigned REM_W = COMP_W + 4;
  // Divider: the dividend is the scaled magnitude plus half the divisor.
  localparam int unsigned DV_W = COMP_W + FRAC_W + 1;
  localparam int unsigned DREM_W = ROOT_W + 1;
  // Width at which saturation is judged.
  localparam int unsigned WIDE_W = 2 * COMP_W + 4;
  // Four output components of four products each.
  localparam int unsigned MUL_STEPS = 16;
  localparam int unsigned STEP_MAX = (DV_W > SQ_N) ?
                                     ((DV_W > MUL_STEPS) ? DV_W : MUL_STEPS) :
                                     ((SQ_N > MUL_STEPS) ? SQ_N : MUL_STEPS);
  localparam int unsigned STEP_W = $clog2(STEP_MAX + 1);

  typedef logic signed [COMP_W-1:0] comp_t;

  // Component indexes as stored.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // Saturation bounds sign-extended to the wide width.
  localparam logic signed [WIDE_W-1:0] CMAX_WIDE =
    {{(WIDE_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] CMIN_WIDE = ~CMAX_WIDE;

  // The value one, reset value of the scalar part.
  localparam comp_t COMP_ONE = comp_t'(1) << FRAC_W;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_NORM  = 3'd5,
    OP_MAG   = 3'd6
  } opcode_e;

  typedef struct packed {
    logic [2:0] opcode;
    comp_t      operand_x;
    comp_t      operand_y;
    comp_t      operand_z;
    comp_t      operand_w;
  } in_item_t;

  typedef struct packed {
    comp_t             result_x;
    comp_t             result_y;
    comp_t             result_z;
    comp_t             result_w;
    logic [COMP_W-1:0] norm_value;
    logic              saturated;
    logic              zero_norm;
  } out_item_t;

  // One term of the Hamilton product: stored index, operand index, subtract flag.
  typedef struct packed {
    logic [1:0] pa;
    logic [1:0] ob;
    logic       neg;
  } mul_term_t;

  typedef struct packed {
    comp_t val;
    logic  hit;
  } clamp_t;

  // Term table: upper two bits pick the output component, lower two the term.
  function automatic mul_term_t mul_term(input logic [3:0] idx);
    mul_term_t t;
    case (idx)
      4'd0:    t = '{pa: IDX_W, ob: IDX_X, neg: 1'b0};
      4'd1:    t = '{pa: IDX_X, ob: IDX_W, neg: 1'b0};
      4'd2:    t = '{pa: IDX_Y, ob: IDX_Z, neg: 1'b0};
      4'd3:    t = '{pa: IDX_Z, ob: IDX_Y, neg: 1'b1};
      4'd4:    t = '{pa: IDX_W, ob: IDX_Y, neg: 1'b0};
      4'd5:    t = '{pa: IDX_Y, ob: IDX_W, neg: 1'b0};
      4'd6:    t = '{pa: IDX_Z, ob: IDX_X, neg: 1'b0};
      4'd7:    t = '{pa: IDX_X, ob: IDX_Z, neg: 1'b1};
      4'd8:    t = '{pa: IDX_W, ob: IDX_Z, neg: 1'b0};
      4'd9:    t = '{pa: IDX_Z, ob: IDX_W, neg: 1'b0};
      4'd10:   t = '{pa: IDX_X, ob: IDX_Y, neg: 1'b0};
      4'd11:   t = '{pa: IDX_Y, ob: IDX_X, neg: 1'b1};
      4'd12:   t = '{pa: IDX_W, ob: IDX_W, neg: 1'b0};
      4'd13:   t = '{pa: IDX_X, ob: IDX_X, neg: 1'b1};
      4'd14:   t = '{pa: IDX_Y, ob: IDX_Y, neg: 1'b1};
      default: t = '{pa: IDX_Z, ob: IDX_Z, neg: 1'b1};
    endcase
    return t;
  endfunction

  // Clamp a wide signed value to the component range and report a clamp.
  function automatic clamp_t clamp_comp(input logic signed [WIDE_W-1:0] v);
    clamp_t r;
    if (v > CMAX_WIDE) begin
      r.val = CMAX_WIDE[COMP_W-1:0];
      r.hit = 1'b1;
    end else if (v < CMIN_WIDE) begin
      r.val = CMIN_WIDE[COMP_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[COMP_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/quaternion_accumulator_alu.sv
// Quaternion accumulator with one shared multiplier, bit-serial square root and divider.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// Every transfer in produces exactly one transfer out. After each operation the
// magnitude is taken with four squares on the multiplier, a 17-step square root and
// one rounding step. Multiply first forms sixteen products on the one multiplier, and
// normalise first runs a square root plus four 29-step divisions, one per component.
// Reset loads the identity and empties the output register. in_stall_o is high while
// an item is worked on; a finished result waiting under out_stall_i in the output
// register does not hold off the next input transfer.
module quaternion_accumulator_alu
  import qacc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_COMMIT = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_ROOT   = 4'd5;
  localparam logic [3:0] S_RND    = 4'd6;
  localparam logic [3:0] S_DIVSET = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DIVEND = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [1:0]            comp_q, comp_d;
  logic                  phase_mag_q, phase_mag_d;
  logic [2:0]            op_q, op_d;
  comp_t                 q_q [4];
  comp_t                 q_d [4];
  comp_t                 nq_q [4];
  comp_t                 nq_d [4];
  comp_t                 opnd_q [4];
  comp_t                 opnd_d [4];
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [REM_W-1:0]      rt_rem_q, rt_rem_d;
  logic [ROOT_W-1:0]     rt_root_q, rt_root_d;
  logic [ROOT_W-1:0]     div_r_q, div_r_d;
  logic [DV_W-1:0]       div_num_q, div_num_d;
  logic [ROOT_W-1:0]     div_rem_q, div_rem_d;
  logic                  sat_q, sat_d;
  logic                  zn_q, zn_d;
  logic [COMP_W-1:0]     norm_q, norm_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  // Shared multiplier and accumulator.
  mul_term_t                 term;
  logic [1:0]                sel_a;
  comp_t                     mul_a, mul_b;
  logic signed [2*COMP_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_x, term_v, acc_base, acc_sum;
  logic signed [ACC_W-1:0]   acc_rnd, acc_shr;
  clamp_t                    mul_c;
  logic [1:0]                mul_idx;

  assign term    = mul_term(step_q[3:0]);
  assign sel_a   = (state_q == S_MUL) ? term.pa : step_q[1:0];
  assign mul_a   = q_q[sel_a];
  assign mul_b   = (state_q == S_MUL) ? opnd_q[term.ob] : q_q[sel_a];
  assign prod    = mul_a * mul_b;
  assign prod_x  = $signed({{(ACC_W-2*COMP_W){prod[2*COMP_W-1]}}, prod});
  assign term_v  = ((state_q == S_MUL) && term.neg) ? -prod_x : prod_x;
  assign acc_base = (step_q[1:0] == 2'd0) ? '0 : acc_q;
  assign acc_sum = acc_base + term_v;

  // Rounding of a finished product sum: add one half, then floor shift.
  assign acc_rnd = acc_q + (ACC_W'(1) <<< (FRAC_W - 1));
  assign acc_shr = acc_rnd >>> FRAC_W;
  assign mul_c   = clamp_comp(WIDE_W'(acc_shr));
  assign mul_idx = step_q[3:2] - 2'd1;

  // Square root iteration on the pair of bits at the top of the accumulator.
  logic [REM_W-1:0]  rt_sh, rt_trial;
  logic              rt_ge;
  logic [ROOT_W-1:0] r_rnd;
  logic [COMP_W-1:0] norm_sat;
  logic              s_zero;

  assign rt_sh    = {rt_rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]};
  assign rt_trial = REM_W'({rt_root_q, 2'b01});
  assign rt_ge    = rt_sh >= rt_trial;
  assign r_rnd    = rt_root_q + ROOT_W'(rt_rem_q > REM_W'(rt_root_q));
  assign norm_sat = r_rnd[ROOT_W-1] ? '1 : r_rnd[COMP_W-1:0];
  assign s_zero   = (rt_root_q == '0) && (rt_rem_q == '0);

  // Divider set-up and restoring step.
  comp_t                   dv_c;
  logic [COMP_W-1:0]       dv_abs;
  logic [DV_W-1:0]         dv_num0;
  logic [DREM_W-1:0]       dv_sh, dv_diff;
  logic                    dv_ge;
  logic signed [WIDE_W-1:0] dv_mag, dv_val;
  clamp_t                  dv_c_cl;

  assign dv_c    = q_q[comp_q];
  assign dv_abs  = dv_c[COMP_W-1] ? (~dv_c + 1'b1) : dv_c;
  assign dv_num0 = (DV_W'(dv_abs) << FRAC_W) + DV_W'(div_r_q >> 1);
  assign dv_sh   = {div_rem_q, div_num_q[DV_W-1]};
  assign dv_diff = dv_sh - DREM_W'(div_r_q);
  assign dv_ge   = dv_sh >= DREM_W'(div_r_q);
  assign dv_mag  = $signed({{(WIDE_W-DV_W){1'b0}}, div_num_q});
  assign dv_val  = dv_c[COMP_W-1] ? -dv_mag : dv_mag;
  assign dv_c_cl = clamp_comp(dv_val);

  // Add, subtract and conjugate on every component at once; a conjugate keeps the scalar part.
  clamp_t simp_c [4];
  logic signed [WIDE_W-1:0] ps_w [4];
  logic signed [WIDE_W-1:0] os_w [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ps_w[i] = WIDE_W'(q_q[i]);
      os_w[i] = WIDE_W'(opnd_q[i]);
      case (op_q)
        OP_ADD:  simp_c[i] = clamp_comp(ps_w[i] + os_w[i]);
        OP_SUB:  simp_c[i] = clamp_comp(ps_w[i] - os_w[i]);
        OP_CONJ: simp_c[i] = clamp_comp(-ps_w[i]);
        default: simp_c[i] = '{val: q_q[i], hit: 1'b0};
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    comp_d      = comp_q;
    phase_mag_d = phase_mag_q;
    op_d        = op_q;
    q_d         = q_q;
    nq_d        = nq_q;
    opnd_d      = opnd_q;
    acc_d       = acc_q;
    rt_rem_d    = rt_rem_q;
    rt_root_d   = rt_root_q;
    div_r_d     = div_r_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    sat_d       = sat_q;
    zn_d        = zn_q;
    norm_d      = norm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d            = in_data_i.opcode;
          opnd_d[IDX_X]   = in_data_i.operand_x;
          opnd_d[IDX_Y]   = in_data_i.operand_y;
          opnd_d[IDX_Z]   = in_data_i.operand_z;
          opnd_d[IDX_W]   = in_data_i.operand_w;
          nq_d            = q_q;
          sat_d           = 1'b0;
          zn_d            = 1'b0;
          phase_mag_d     = 1'b0;
          step_d          = '0;
          if (in_data_i.opcode == OP_MUL) begin
            state_d = S_MUL;
          end else if (in_data_i.opcode == OP_NORM) begin
            state_d = S_SQ;
          end else begin
            state_d = S_SIMPLE;
          end
        end
      end

      S_SIMPLE: begin
        if (op_q == OP_LOAD) begin
          nq_d = opnd_q;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if ((op_q != OP_CONJ) || (i != int'(IDX_W))) begin
              nq_d[i] = simp_c[i].val;
              sat_d   = sat_d | simp_c[i].hit;
            end
          end
        end
        state_d = S_COMMIT;
      end

      // One product a cycle; a finished sum is rounded in the cycle after its last product.
      S_MUL: begin
        if (step_q != STEP_W'(MUL_STEPS)) begin
          acc_d = acc_sum;
        end
        if ((step_q != '0) && (step_q[1:0] == 2'd0)) begin
          nq_d[mul_idx] = mul_c.val;
          sat_d         = sat_q | mul_c.hit;
        end
        if (step_q == STEP_W'(MUL_STEPS)) begin
          state_d = S_COMMIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      S_COMMIT: begin
        q_d         = nq_q;
        phase_mag_d = 1'b1;
        step_d      = '0;
        state_d     = S_SQ;
      end

      // Sum of squares of the stored quaternion.
      S_SQ: begin
        acc_d = acc_sum;
        if (step_q == STEP_W'(3)) begin
          step_d    = '0;
          rt_rem_d  = '0;
          rt_root_d = '0;
          state_d   = S_ROOT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      S_ROOT: begin
        rt_rem_d  = rt_ge ? (rt_sh - rt_trial) : rt_sh;
        rt_root_d = {rt_root_q[ROOT_W-2:0], rt_ge};
        acc_d     = acc_q <<< 2;
        if (step_q == STEP_W'(SQ_N - 1)) begin
          state_d = S_RND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      S_RND: begin
        if (phase_mag_q) begin
          norm_d  = norm_sat;
          state_d = S_DONE;
        end else if (s_zero) begin
          zn_d    = 1'b1;
          state_d = S_COMMIT;
        end else begin
          div_r_d = r_rnd;
          comp_d  = '0;
          state_d = S_DIVSET;
        end
      end

      S_DIVSET: begin
        div_num_d = dv_num0;
        div_rem_d = '0;
        step_d    = '0;
        state_d   = S_DIV;
      end

      // One quotient bit a cycle.
      S_DIV: begin
        div_rem_d = dv_ge ? dv_diff[ROOT_W-1:0] : dv_sh[ROOT_W-1:0];
        div_num_d = {div_num_q[DV_W-2:0], dv_ge};
        if (step_q == STEP_W'(DV_W - 1)) begin
          state_d = S_DIVEND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      S_DIVEND: begin
        nq_d[comp_q] = dv_c_cl.val;
        sat_d        = sat_q | dv_c_cl.hit;
        if (comp_q == IDX_W) begin
          state_d = S_COMMIT;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DIVSET;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.result_x     = q_q[IDX_X];
          out_d.result_y     = q_q[IDX_Y];
          out_d.result_z     = q_q[IDX_Z];
          out_d.result_w     = q_q[IDX_W];
          out_d.norm_value   = norm_q;
          out_d.saturated    = sat_q;
          out_d.zero_norm    = zn_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and the stored quaternion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      comp_q      <= '0;
      phase_mag_q <= 1'b0;
      out_valid_q <= 1'b0;
      q_q[IDX_X]  <= '0;
      q_q[IDX_Y]  <= '0;
      q_q[IDX_Z]  <= '0;
      q_q[IDX_W]  <= COMP_ONE;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      comp_q      <= comp_d;
      phase_mag_q <= phase_mag_d;
      out_valid_q <= out_valid_d;
      q_q         <= q_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    nq_q      <= nq_d;
    opnd_q    <= opnd_d;
    acc_q     <= acc_d;
    rt_rem_q  <= rt_rem_d;
    rt_root_q <= rt_root_d;
    div_r_q   <= div_r_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    sat_q     <= sat_d;
    zn_q      <= zn_d;
    norm_q    <= norm_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/quaternion_accumulator_alu_test.sv
// Self-checking testbench for the quaternion accumulator: directed cases, then random traffic.
module quaternion_accumulator_alu_test
  import qacc_pkg::*;
();

  // Run limits, reckoned generously from the slowest operation (normalise).
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned POST_DRAIN_CYCLES = 400;
  localparam int unsigned RANDOM_PER_PHASE = 500;

  // Fixed-point bounds of one component and of the magnitude.
  localparam longint COMP_MAX = (longint'(1) << (COMP_W - 1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;
  localparam longint unsigned NORM_MAX = (longint'(1) << COMP_W) - 1;
  localparam int ONE_RAW = 1 << FRAC_W;

  // The one opcode value that the block does not name; it behaves as read magnitude.
  localparam logic [2:0] OP_SPARE = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  // Expected results in transfer order, and the predicted stored quaternion.
  out_item_t   pending_results[$];
  longint      held_q [4];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count = 0;
  int unsigned cycle_count;

  quaternion_accumulator_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a period of 10 time units.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that is still going at the limit has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Clamp a wide value to the component range, flagging any clamp.
  function automatic longint limit_component(input longint v, inout bit clamped);
    if (v > COMP_MAX) begin
      clamped = 1'b1;
      return COMP_MAX;
    end
    if (v < COMP_MIN) begin
      clamped = 1'b1;
      return COMP_MIN;
    end
    return v;
  endfunction

  // Round a sum of products to nearest, ties towards plus infinity, then clamp.
  function automatic longint round_product_sum(input longint total, inout bit clamped);
    return limit_component((total + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W, clamped);
  endfunction

  // Square root rounded to nearest, digit by digit.
  function automatic longint unsigned round_sqrt(input longint unsigned s);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned step;
    rest = s;
    root = 0;
    step = longint'(1) << 62;
    while (step > rest) step >>= 2;
    while (step != 0) begin
      if (rest >= root + step) begin
        rest -= root + step;
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    if (s - root * root > root) root++;
    return root;
  endfunction

  // Exact sum of the squared components of the stored quaternion.
  function automatic longint unsigned sum_of_squares();
    longint unsigned total;
    longint unsigned part;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      part = (held_q[i] < 0) ? -held_q[i] : held_q[i];
      total += part * part;
    end
    return total;
  endfunction

  // Apply one operation to the predicted quaternion and work out the result it reports.
  function automatic out_item_t predict_step(input in_item_t item);
    longint          opnd [4];
    longint          prev [4];
    longint unsigned root;
    longint unsigned part;
    longint unsigned scaled;
    bit              clamped;
    bit              zero_mag;
    out_item_t       res;
    opnd[IDX_X] = longint'(item.operand_x);
    opnd[IDX_Y] = longint'(item.operand_y);
    opnd[IDX_Z] = longint'(item.operand_z);
    opnd[IDX_W] = longint'(item.operand_w);
    for (int i = 0; i < 4; i++) prev[i] = held_q[i];
    clamped = 1'b0;
    zero_mag = 1'b0;
    case (item.opcode)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) held_q[i] = opnd[i];
      end
      OP_ADD: begin
        for (int i = 0; i < 4; i++) held_q[i] = limit_component(prev[i] + opnd[i], clamped);
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) held_q[i] = limit_component(prev[i] - opnd[i], clamped);
      end
      OP_MUL: begin
        // Hamilton product, stored value on the left.
        held_q[IDX_W] = round_product_sum(prev[IDX_W] * opnd[IDX_W] - prev[IDX_X] * opnd[IDX_X]
                        - prev[IDX_Y] * opnd[IDX_Y] - prev[IDX_Z] * opnd[IDX_Z], clamped);
        held_q[IDX_X] = round_product_sum(prev[IDX_W] * opnd[IDX_X] + prev[IDX_X] * opnd[IDX_W]
                        + prev[IDX_Y] * opnd[IDX_Z] - prev[IDX_Z] * opnd[IDX_Y], clamped);
        held_q[IDX_Y] = round_product_sum(prev[IDX_W] * opnd[IDX_Y] + prev[IDX_Y] * opnd[IDX_W]
                        + prev[IDX_Z] * opnd[IDX_X] - prev[IDX_X] * opnd[IDX_Z], clamped);
        held_q[IDX_Z] = round_product_sum(prev[IDX_W] * opnd[IDX_Z] + prev[IDX_Z] * opnd[IDX_W]
                        + prev[IDX_X] * opnd[IDX_Y] - prev[IDX_Y] * opnd[IDX_X], clamped);
      end
      OP_CONJ: begin
        held_q[IDX_X] = limit_component(-prev[IDX_X], clamped);
        held_q[IDX_Y] = limit_component(-prev[IDX_Y], clamped);
        held_q[IDX_Z] = limit_component(-prev[IDX_Z], clamped);
      end
      OP_NORM: begin
        // A zero magnitude leaves the quaternion alone and raises the flag.
        if (sum_of_squares() == 0) begin
          zero_mag = 1'b1;
        end else begin
          root = round_sqrt(sum_of_squares());
          for (int i = 0; i < 4; i++) begin
            part = (prev[i] < 0) ? -prev[i] : prev[i];
            scaled = ((part << FRAC_W) + (root >> 1)) / root;
            held_q[i] = limit_component(prev[i] < 0 ? -longint'(scaled) : longint'(scaled),
                                        clamped);
          end
        end
      end
      default: ;
    endcase
    root = round_sqrt(sum_of_squares());
    if (root > NORM_MAX) root = NORM_MAX;
    res.result_x   = comp_t'(held_q[IDX_X]);
    res.result_y   = comp_t'(held_q[IDX_Y]);
    res.result_z   = comp_t'(held_q[IDX_Z]);
    res.result_w   = comp_t'(held_q[IDX_W]);
    res.norm_value = root[COMP_W-1:0];
    res.saturated  = clamped;
    res.zero_norm  = zero_mag;
    return res;
  endfunction

  // Present one item, idling beforehand at random, and wait for its transfer.
  task automatic send_item(input logic [2:0] op, input comp_t ox, input comp_t oy,
                           input comp_t oz, input comp_t ow);
    in_item_t item;
    item = '{opcode: op, operand_x: ox, operand_y: oy, operand_z: oz, operand_w: ow};
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_step(item));
  endtask

  // Compare one field of a result and report a mismatch.
  task automatic check_field(input string name, input logic [COMP_W-1:0] want,
                             input logic [COMP_W-1:0] got, input bit is_signed);
    if (got !== want) begin
      if (is_signed)
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      else
        $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Receiver: stall at random on every cycle.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Each result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: x %0d y %0d z %0d w %0d",
               $signed(out_data_o.result_x), $signed(out_data_o.result_y),
               $signed(out_data_o.result_z), $signed(out_data_o.result_w));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_x", want.result_x, out_data_o.result_x, 1'b1);
        check_field("result_y", want.result_y, out_data_o.result_y, 1'b1);
        check_field("result_z", want.result_z, out_data_o.result_z, 1'b1);
        check_field("result_w", want.result_w, out_data_o.result_w, 1'b1);
        check_field("norm_value", want.norm_value, out_data_o.norm_value, 1'b0);
        check_field("saturated", COMP_W'(want.saturated), COMP_W'(out_data_o.saturated),
                    1'b0);
        check_field("zero_norm", COMP_W'(want.zero_norm), COMP_W'(out_data_o.zero_norm),
                    1'b0);
      end
    end
  end

  // Random component: mostly near unit size, some full-range, extreme or tiny values.
  function automatic comp_t random_component();
    case ($urandom_range(9)) inside
      [0:4]:   return comp_t'(int'($urandom_range(3 * ONE_RAW)) - (3 * ONE_RAW) / 2);
      [5:6]:   return comp_t'($urandom());
      7: begin
        case ($urandom_range(3))
          0:       return comp_t'(COMP_MAX);
          1:       return comp_t'(COMP_MIN);
          2:       return comp_t'(0);
          default: return comp_t'(-1);
        endcase
      end
      default: return comp_t'(int'($urandom_range(64)) - 32);
    endcase
  endfunction

  // After reset the stored value is the identity.
  task automatic test_reset_identity();
    send_item(OP_MAG, 0, 0, 0, 0);
  endtask

  // Loads at the component extremes, including a magnitude that saturates.
  task automatic test_load_extremes();
    send_item(OP_LOAD, comp_t'(COMP_MAX), comp_t'(COMP_MAX), comp_t'(COMP_MAX),
              comp_t'(COMP_MAX));
    send_item(OP_LOAD, comp_t'(COMP_MIN), comp_t'(COMP_MIN), comp_t'(COMP_MIN),
              comp_t'(COMP_MIN));
    send_item(OP_LOAD, comp_t'(COMP_MIN), comp_t'(COMP_MAX), 0, -1);
  endtask

  // Add and subtract, within range and saturating both ways.
  task automatic test_add_subtract();
    send_item(OP_ADD, comp_t'(COMP_MAX), comp_t'(COMP_MIN), 1, -1);
    send_item(OP_ADD, comp_t'(COMP_MAX), comp_t'(COMP_MIN), comp_t'(COMP_MAX),
              comp_t'(COMP_MIN));
    send_item(OP_SUB, comp_t'(COMP_MIN), comp_t'(COMP_MAX), comp_t'(COMP_MIN),
              comp_t'(COMP_MAX));
    send_item(OP_SUB, 1, 2, 3, 4);
  endtask

  // Hamilton product: identity, rotate by vector, saturation and rounding ties.
  task automatic test_multiply();
    send_item(OP_LOAD, 1024, -2048, 512, 3072);
    send_item(OP_MUL, 0, 0, 0, comp_t'(ONE_RAW));
    send_item(OP_MUL, comp_t'(ONE_RAW), comp_t'(-ONE_RAW / 2), comp_t'(ONE_RAW / 4), 0);
    send_item(OP_LOAD, comp_t'(COMP_MAX), comp_t'(COMP_MAX), comp_t'(COMP_MAX),
              comp_t'(COMP_MAX));
    send_item(OP_MUL, comp_t'(COMP_MAX), comp_t'(COMP_MIN), comp_t'(COMP_MAX),
              comp_t'(COMP_MAX));
    // A product of exactly one half rounds up, minus one half rounds up to zero.
    send_item(OP_LOAD, 0, 0, 0, 1);
    send_item(OP_MUL, 0, 0, 0, comp_t'(ONE_RAW / 2));
    send_item(OP_MUL, 0, 0, 0, comp_t'(-ONE_RAW / 2));
  endtask

  // Conjugate, including negation of the most negative value.
  task automatic test_conjugate();
    send_item(OP_LOAD, comp_t'(COMP_MIN), comp_t'(COMP_MAX), -5, 9);
    send_item(OP_CONJ, comp_t'(COMP_MAX), 123, -77, comp_t'(COMP_MIN));
  endtask

  // Normalise a zero quaternion, an ordinary one and a very small one.
  task automatic test_normalise();
    send_item(OP_LOAD, 0, 0, 0, 0);
    send_item(OP_NORM, 11, 22, 33, 44);
    send_item(OP_LOAD, comp_t'(3 * ONE_RAW), 0, comp_t'(4 * ONE_RAW), 0);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, 1, 0, 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);
  endtask

  // The unnamed opcode and read magnitude leave the value unchanged whatever the operands.
  task automatic test_unused_opcode();
    send_item(OP_SPARE, comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom()),
              comp_t'($urandom()));
    send_item(OP_MAG, comp_t'(COMP_MAX), comp_t'(COMP_MIN), comp_t'(COMP_MAX),
              comp_t'(COMP_MIN));
  endtask

  // Random operations with a bias towards multiply and regular reloads.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic [2:0]  op;
    comp_t       ow;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 14)      op = OP_LOAD;
      else if (pick < 26) op = OP_ADD;
      else if (pick < 38) op = OP_SUB;
      else if (pick < 58) op = OP_MUL;
      else if (pick < 68) op = OP_CONJ;
      else if (pick < 80) op = OP_NORM;
      else if (pick < 92) op = OP_MAG;
      else                op = OP_SPARE;
      ow = random_component();
      // A quarter of the multiplies rotate by a pure vector.
      if (op == OP_MUL && $urandom_range(3) == 0) ow = 0;
      send_item(op, random_component(), random_component(), random_component(), ow);
    end
  endtask

  // Stop sending, then wait for every expected result and a little beyond.
  task automatic finish_traffic();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (POST_DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sequence of the run.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_gap_pct   = 23;
    recv_stall_pct = 53;
    held_q         = '{0, 0, 0, ONE_RAW};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_identity();
    test_load_extremes();
    test_add_subtract();
    test_multiply();
    test_conjugate();
    test_normalise();
    test_unused_opcode();

    test_random_traffic(RANDOM_PER_PHASE);
    send_gap_pct   = 53;
    recv_stall_pct = 23;
    test_random_traffic(RANDOM_PER_PHASE);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_PER_PHASE);

    finish_traffic();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
